FILE: design/pwm_pkg.sv
// Shared constants, register codes and the command/status structs of the pooling core.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing.
package pwm_pkg;

  // Line store geometry: MaxWindow rows of MaxMapWidth pixels, both powers of two.
  localparam int MaxMapWidth  = 256;
  localparam int MaxWindow    = 8;
  localparam int MaxMapHeight = 4096;
  localparam int MaxMapCount  = 1024;

  localparam int PixBits       = 16;
  localparam int ColBits       = $clog2(MaxMapWidth);
  localparam int WinCntBits    = $clog2(MaxWindow);
  localparam int StoreDepth    = MaxWindow * MaxMapWidth;
  localparam int StoreAddrBits = $clog2(StoreDepth);
  localparam int RowBits       = $clog2(MaxMapHeight);
  localparam int MapBits       = $clog2(MaxMapCount);

  // Register widths.
  localparam int MapWidthBits  = 9;
  localparam int MapHeightBits = 13;
  localparam int WinBits       = 4;
  localparam int StrideBits    = 4;
  localparam int MapCountBits  = 11;
  localparam int CfgDataBits   = 13;
  localparam int CfgIndexBits  = 3;

  // Register reset values.
  localparam int MapWidthReset  = 32;
  localparam int MapHeightReset = 32;
  localparam int WinReset       = 2;
  localparam int StrideReset    = 2;
  localparam int MapCountReset  = 1;

  // Window arithmetic: area up to MaxWindow squared, sum of up to that many pixels.
  localparam int KkBits   = 2 * WinCntBits + 1;
  localparam int SumBits  = PixBits + 2 * WinCntBits + 1;
  localparam int MagBits  = SumBits - 1;
  localparam int StepBits = $clog2(MagBits);

  localparam int PhaseSteps = RowBits;
  localparam int DivSteps   = MagBits;

  localparam logic signed [PixBits-1:0] MinPixel = -16'sd32768;
  localparam logic PoolMax = 1'b0;
  localparam logic PoolAvg = 1'b1;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_MAP_WIDTH     = 3'd0,
    REG_MAP_HEIGHT    = 3'd1,
    REG_WINDOW_SIZE   = 3'd2,
    REG_WINDOW_STRIDE = 3'd3,
    REG_POOL_MODE     = 3'd4,
    REG_MAP_COUNT     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic accept;
    logic phase_start;
    logic phase_step;
    logic phase_done;
    logic rd_step;
    logic div_start;
    logic div_step;
    logic out_load;
  } pwm_cmd_t;

  typedef struct packed {
    logic dirty;
    logic emit;
    logic rd_last;
    logic avg_mode;
  } pwm_sts_t;

endpackage

FILE: design/pooling_window_max_avg_core.sv
// Top level of the 2D max/average pooling core.
// Depends on pwm_pkg, pwm_ctrl and pwm_datapath (which holds the pwm_ram line store).
//
//   Channel   Direction  Carries
//   s_axis    in         tdata[15:0] pixel
//   m_axis    out        tdata[15:0] pooled_value, tlast last_of_map, tuser last_of_layer
//   cfg       in         cfg_index_i register index, cfg_data_i value
//
// A pixel that closes no window needs no further work. One that closes a window is
// followed by one store read per window pixel and, in average mode only, by a
// one-bit-per-cycle 22-step divide. After reset and after any register write a pass
// of one load step and twelve remainder steps recomputes the stride phases, with
// s_axis_tready low.
// A waiting result stalls the core only when the next result is ready to load.
module pooling_window_max_avg_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // [15:0] pixel
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // [15:0] pooled_value
  output logic                             m_axis_tlast,
  output logic                             m_axis_tuser,  // [0] last_of_layer
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pwm_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [pwm_pkg::CfgDataBits-1:0]  cfg_data_i
);
  import pwm_pkg::*;

  pwm_cmd_t cmd;
  pwm_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pwm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  pwm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_i        (s_axis_tdata),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pooled_value_o (m_axis_tdata),
    .last_of_map_o  (m_axis_tlast),
    .last_of_layer_o(m_axis_tuser)
  );

endmodule

FILE: design/pwm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the pooling line store; depends on nothing.
module pwm_ram #(
  parameter int Width = 16,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pwm_ctrl.sv
// Controller state machine of the pooling core: handshakes, read sweep, divide and output load.
// Depends on pwm_pkg; drives the datapath through pwm_cmd_t and watches pwm_sts_t.
module pwm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  input  pwm_pkg::pwm_sts_t sts_i,
  output pwm_pkg::pwm_cmd_t cmd_o
);
  import pwm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_READ,
    ST_LAST,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e               state_q, state_d;
  logic [StepBits-1:0]  cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  pwm_cmd_t             cmd;
  logic                 tready;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    tready  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (sts_i.dirty) begin
          cmd.phase_start = 1'b1;
          cnt_d           = '0;
          state_d         = ST_PHASE;
        end else begin
          tready = 1'b1;
          if (s_axis_tvalid_i) begin
            cmd.accept = 1'b1;
            if (sts_i.emit) begin
              state_d = ST_READ;
            end
          end
        end
      end
      ST_PHASE: begin
        cmd.phase_step = 1'b1;
        if (cnt_q == StepBits'(PhaseSteps - 1)) begin
          cmd.phase_done = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cnt_d = cnt_q + StepBits'(1);
        end
      end
      ST_READ: begin
        cmd.rd_step = 1'b1;
        if (sts_i.rd_last) begin
          state_d = ST_LAST;
        end
      end
      // The last read word lands in the accumulators at the end of this cycle.
      ST_LAST: begin
        state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd.div_start = 1'b1;
        cnt_d         = '0;
        state_d       = sts_i.avg_mode ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_q == StepBits'(DivSteps - 1)) begin
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q + StepBits'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o           = cmd;
  assign s_axis_tready_o = tready;
  assign m_axis_tvalid_o = out_valid_q;

endmodule

FILE: design/pwm_datapath.sv
// Datapath of the pooling core: registers, positions, stride phases, line store,
// window accumulators, restoring divider and output register.
// Depends on pwm_pkg and pwm_ram; commanded by pwm_ctrl.
module pwm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [pwm_pkg::CfgIndexBits-1:0]  cfg_index_i,
  input  logic [pwm_pkg::CfgDataBits-1:0]   cfg_data_i,
  input  logic [pwm_pkg::PixBits-1:0]       pixel_i,
  input  pwm_pkg::pwm_cmd_t                 cmd_i,
  output pwm_pkg::pwm_sts_t                 sts_o,
  output logic [pwm_pkg::PixBits-1:0]       pooled_value_o,
  output logic                              last_of_map_o,
  output logic                              last_of_layer_o
);
  import pwm_pkg::*;

  localparam int PhaseLanes = 3;

  // Configuration registers.
  logic [MapWidthBits-1:0]  map_width_q;
  logic [MapHeightBits-1:0] map_height_q;
  logic [WinBits-1:0]       window_size_q;
  logic [StrideBits-1:0]    window_stride_q;
  logic                     pool_mode_q;
  logic [MapCountBits-1:0]  map_count_q;
  logic                     dirty_q;

  // Clamped register values.
  logic [MapWidthBits-1:0]  w_c;
  logic [MapHeightBits-1:0] h_c;
  logic [WinBits-1:0]       k_c, km1;
  logic [StrideBits-1:0]    s_c;
  logic [MapCountBits-1:0]  n_c;

  // Positions and their phases against the stride grid.
  logic [RowBits-1:0]    row_q, row_d;
  logic [ColBits-1:0]    col_q, col_d;
  logic [MapBits-1:0]    maps_q, maps_d;
  logic [StrideBits-1:0] rm_q, rm_d, cm_q, cm_d, km_q, km_d;

  logic [MapWidthBits-1:0]  col_inc;
  logic [MapHeightBits-1:0] row_inc;
  logic [MapCountBits-1:0]  maps_inc;
  logic                     col_end, row_end, map_last, in_bounds, emit, lmap, llay;

  // Remainder lanes: row mod stride, column mod stride, (window - 1) mod stride.
  logic [RowBits-1:0]    ph_div_q [PhaseLanes];
  logic [StrideBits-1:0] ph_rem_q [PhaseLanes];
  logic [StrideBits-1:0] ph_rem_nx [PhaseLanes];
  logic [StrideBits:0]   ph_t [PhaseLanes];

  // Window read sweep.
  logic [WinCntBits-1:0] win_row_q, ri_q, rj_q, km1w;
  logic [ColBits-1:0]    win_col_q;
  logic                  rd_valid_q;
  logic [StoreAddrBits-1:0] waddr, raddr;
  logic [PixBits-1:0]    rdata;
  logic signed [PixBits-1:0] rd_s;
  logic signed [PixBits-1:0] best_q;
  logic signed [SumBits-1:0] sum_q;
  logic                  lmap_q, llay_q;

  // Divider.
  logic [MagBits-1:0]  dv_q;
  logic [KkBits-1:0]   drem_q, kk;
  logic [KkBits:0]     dt;
  logic                dbit, neg_q;
  logic [SumBits-1:0]  sum_abs;
  logic [PixBits-1:0]  q16, avg;

  logic [PixBits-1:0] pooled_value_q;
  logic               last_of_map_q, last_of_layer_q;

  function automatic logic [StrideBits-1:0] step_mod(input logic [StrideBits-1:0] x,
                                                     input logic [StrideBits-1:0] m);
    logic [StrideBits-1:0] y;
    y = x + StrideBits'(1);
    return (y == m) ? '0 : y;
  endfunction

  always_comb begin
    w_c = map_width_q;
    if (map_width_q == '0) begin
      w_c = MapWidthBits'(1);
    end else if (map_width_q > MapWidthBits'(MaxMapWidth)) begin
      w_c = MapWidthBits'(MaxMapWidth);
    end
    h_c = map_height_q;
    if (map_height_q == '0) begin
      h_c = MapHeightBits'(1);
    end else if (map_height_q > MapHeightBits'(MaxMapHeight)) begin
      h_c = MapHeightBits'(MaxMapHeight);
    end
    k_c = window_size_q;
    if (window_size_q == '0) begin
      k_c = WinBits'(1);
    end else if (window_size_q > WinBits'(MaxWindow)) begin
      k_c = WinBits'(MaxWindow);
    end
    s_c = (window_stride_q == '0) ? StrideBits'(1) : window_stride_q;
    n_c = map_count_q;
    if (map_count_q == '0) begin
      n_c = MapCountBits'(1);
    end else if (map_count_q > MapCountBits'(MaxMapCount)) begin
      n_c = MapCountBits'(MaxMapCount);
    end
  end

  assign km1  = k_c - WinBits'(1);
  assign km1w = km1[WinCntBits-1:0];

  assign col_inc  = MapWidthBits'(col_q) + MapWidthBits'(1);
  assign row_inc  = MapHeightBits'(row_q) + MapHeightBits'(1);
  assign maps_inc = MapCountBits'(maps_q) + MapCountBits'(1);
  assign col_end  = col_inc >= w_c;
  assign row_end  = row_inc >= h_c;
  assign map_last = maps_inc >= n_c;

  assign in_bounds = (MapHeightBits'(row_q) < h_c) && (MapWidthBits'(col_q) < w_c);
  // A window closes here when both coordinates have reached window - 1 and sit on
  // the same stride phase as window - 1.
  assign emit = in_bounds && (RowBits'(km1) <= row_q) && (ColBits'(km1) <= col_q) &&
                (rm_q == km_q) && (cm_q == km_q);
  assign lmap = ((MapHeightBits'(row_q) + MapHeightBits'(s_c)) >= h_c) &&
                ((MapWidthBits'(col_q) + MapWidthBits'(s_c)) >= w_c);
  assign llay = lmap && map_last;

  always_comb begin
    for (int l = 0; l < PhaseLanes; l++) begin
      ph_t[l] = {ph_rem_q[l], ph_div_q[l][RowBits-1]};
      if (ph_t[l] >= {1'b0, s_c}) begin
        ph_rem_nx[l] = StrideBits'(ph_t[l] - {1'b0, s_c});
      end else begin
        ph_rem_nx[l] = StrideBits'(ph_t[l]);
      end
    end
  end

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    maps_d = maps_q;
    rm_d   = rm_q;
    cm_d   = cm_q;
    km_d   = km_q;
    if (cmd_i.phase_done) begin
      rm_d = ph_rem_nx[0];
      cm_d = ph_rem_nx[1];
      km_d = ph_rem_nx[2];
    end else if (cmd_i.accept) begin
      if (col_end) begin
        col_d = '0;
        cm_d  = '0;
        if (row_end) begin
          row_d  = '0;
          rm_d   = '0;
          maps_d = map_last ? '0 : MapBits'(maps_inc);
        end else begin
          row_d = RowBits'(row_inc);
          rm_d  = step_mod(rm_q, s_c);
        end
      end else begin
        col_d = ColBits'(col_inc);
        cm_d  = step_mod(cm_q, s_c);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q     <= MapWidthBits'(MapWidthReset);
      map_height_q    <= MapHeightBits'(MapHeightReset);
      window_size_q   <= WinBits'(WinReset);
      window_stride_q <= StrideBits'(StrideReset);
      pool_mode_q     <= PoolMax;
      map_count_q     <= MapCountBits'(MapCountReset);
      dirty_q         <= 1'b1;
      row_q           <= '0;
      col_q           <= '0;
      maps_q          <= '0;
      rm_q            <= '0;
      cm_q            <= '0;
      km_q            <= '0;
      rd_valid_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_MAP_WIDTH:     map_width_q     <= cfg_data_i[MapWidthBits-1:0];
          REG_MAP_HEIGHT:    map_height_q    <= cfg_data_i[MapHeightBits-1:0];
          REG_WINDOW_SIZE:   window_size_q   <= cfg_data_i[WinBits-1:0];
          REG_WINDOW_STRIDE: window_stride_q <= cfg_data_i[StrideBits-1:0];
          REG_POOL_MODE:     pool_mode_q     <= cfg_data_i[0];
          REG_MAP_COUNT:     map_count_q     <= cfg_data_i[MapCountBits-1:0];
          default: ;
        endcase
      end
      // A write after the phase pass started leaves the flag set, so the pass is rerun.
      if (cfg_valid_i) begin
        dirty_q <= 1'b1;
      end else if (cmd_i.phase_start) begin
        dirty_q <= 1'b0;
      end
      row_q      <= row_d;
      col_q      <= col_d;
      maps_q     <= maps_d;
      rm_q       <= rm_d;
      cm_q       <= cm_d;
      km_q       <= km_d;
      rd_valid_q <= cmd_i.rd_step;
    end
  end

  // Remainder lanes, window sweep, accumulators, divider and output register carry payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.phase_start) begin
      ph_div_q[0] <= row_q;
      ph_div_q[1] <= RowBits'(col_q);
      ph_div_q[2] <= RowBits'(km1);
      for (int l = 0; l < PhaseLanes; l++) begin
        ph_rem_q[l] <= '0;
      end
    end else if (cmd_i.phase_step) begin
      for (int l = 0; l < PhaseLanes; l++) begin
        ph_div_q[l] <= {ph_div_q[l][RowBits-2:0], 1'b0};
        ph_rem_q[l] <= ph_rem_nx[l];
      end
    end

    if (cmd_i.accept) begin
      win_row_q <= row_q[WinCntBits-1:0];
      win_col_q <= col_q;
      ri_q      <= '0;
      rj_q      <= '0;
      best_q    <= MinPixel;
      sum_q     <= '0;
      lmap_q    <= lmap;
      llay_q    <= llay;
    end else begin
      if (cmd_i.rd_step) begin
        if (rj_q == km1w) begin
          rj_q <= '0;
          ri_q <= ri_q + WinCntBits'(1);
        end else begin
          rj_q <= rj_q + WinCntBits'(1);
        end
      end
      if (rd_valid_q) begin
        if (rd_s > best_q) begin
          best_q <= rd_s;
        end
        sum_q <= sum_q + SumBits'(rd_s);
      end
    end

    if (cmd_i.div_start) begin
      dv_q   <= sum_abs[MagBits-1:0];
      drem_q <= '0;
      neg_q  <= sum_q[SumBits-1];
    end else if (cmd_i.div_step) begin
      dv_q   <= {dv_q[MagBits-2:0], dbit};
      drem_q <= dbit ? KkBits'(dt - {1'b0, kk}) : KkBits'(dt);
    end

    if (cmd_i.out_load) begin
      pooled_value_q  <= (pool_mode_q == PoolAvg) ? avg : best_q;
      last_of_map_q   <= lmap_q;
      last_of_layer_q <= llay_q;
    end
  end

  assign waddr = {row_q[WinCntBits-1:0], col_q};
  assign raddr = {win_row_q - ri_q, win_col_q - ColBits'(rj_q)};
  assign rd_s  = rdata;

  pwm_ram #(
    .Width(PixBits),
    .Depth(StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept && in_bounds),
    .waddr_i(waddr),
    .wdata_i(pixel_i),
    .re_i   (cmd_i.rd_step),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign kk      = KkBits'(k_c * k_c);
  assign sum_abs = sum_q[SumBits-1] ? (~sum_q + SumBits'(1)) : sum_q;
  assign dt      = {drem_q, dv_q[MagBits-1]};
  assign dbit    = dt >= {1'b0, kk};
  // The quotient magnitude never exceeds 32768, so sixteen bits hold it before negation.
  assign q16     = dv_q[PixBits-1:0];
  assign avg     = neg_q ? (~q16 + PixBits'(1)) : q16;

  assign sts_o.dirty    = dirty_q;
  assign sts_o.emit     = emit;
  assign sts_o.rd_last  = (ri_q == km1w) && (rj_q == km1w);
  assign sts_o.avg_mode = (pool_mode_q == PoolAvg);

  assign pooled_value_o  = pooled_value_q;
  assign last_of_map_o   = last_of_map_q;
  assign last_of_layer_o = last_of_layer_q;

endmodule

FILE: design/pwm_checker.sv
// Port-level checker for the pooling core, attached to the top level by bind.
// Depends on pwm_pkg for the configuration port widths.
module pwm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [15:0]                      s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [15:0]                      m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic                             m_axis_tuser,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [pwm_pkg::CfgIndexBits-1:0] cfg_index_i,
  input logic [pwm_pkg::CfgDataBits-1:0]  cfg_data_i
);

  // The last value of a layer is always the last value of its map.
  a_layer_implies_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("last_of_layer without last_of_map");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
       $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // A result needs the window sweep, so it never appears right after a pixel transaction.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("result appeared one cycle after a pixel");

  // A new result is loaded only while no pixel can be taken.
  a_load_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result loaded while accepting pixels");

endmodule

bind pooling_window_max_avg_core pwm_checker u_pwm_checker (.*);
